@@ hdl/bffa_pkg.sv @@
// Shared constants, types and helpers for the bitmap first-free allocator.
package bffa_pkg;

   localparam int MAP_BYTES   = 512;
   localparam int BYTE_W      = 8;
   localparam int ROW_BYTES   = 8;
   localparam int ROWS        = MAP_BYTES / ROW_BYTES;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int LANE_W      = $clog2(ROW_BYTES);
   localparam int BIT_W       = $clog2(BYTE_W);
   localparam int ROW_DATA_W  = ROW_BYTES * BYTE_W;
   localparam int BIDX_W      = 9;
   localparam int SLOT_W      = 12;
   localparam int BSIZE_W     = 17;
   localparam int ADDR_W      = 32;
   localparam int PROD_W      = SLOT_W + BSIZE_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = BSIZE_W'(4096);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_BASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_SCAN,
      ST_PICK,
      ST_MUL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [ROW_W-1:0]      row;
      logic [ROW_DATA_W-1:0] data;
   } map_wr_type;

   // index of the lowest set bit of an eight-bit value (0 if none)
   function automatic logic [BIT_W-1:0] lowest_set8(input logic [BYTE_W-1:0] b);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         if (b[k]) idx = BIT_W'(k);
      end
      return idx;
   endfunction

endpackage

@@ hdl/bffa_map_store.sv @@
// Bitmap store: rows of bitmap bytes in a RAM with registered read data and per-row valid bits.
module bffa_map_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [bffa_pkg::ROW_W-1:0]     rd_row,
   output logic [bffa_pkg::ROW_DATA_W-1:0] rd_data,
   input  bffa_pkg::map_wr_type           wr
);
   import bffa_pkg::*;

   logic [ROW_DATA_W-1:0] mem [ROWS];
   logic [ROWS-1:0]       row_vld_ff;
   logic [ROW_DATA_W-1:0] data_ff;
   logic                  data_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff  <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            row_vld_ff[wr.row] <= 1'b1;
         end
         if (rd_en) begin
            data_vld_ff <= row_vld_ff[rd_row];
         end
      end
   end

   // a row never written reads as all zero (nothing free)
   assign rd_data = data_vld_ff ? data_ff : '0;

endmodule

@@ hdl/bitmap_first_free_allocator.sv @@
// Top level: command decode, row scan sequencer and slot/position computation.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | start, busy, req_command/index/value    | in; busy out
//   response | rsp_valid, rsp_* result fields          | out
//   csr      | csr_valid, csr_ready, csr_index/data    | in; ready out
//
// A load passes from start through ST_LOAD_WR to ST_RESP. An allocate reads one
// 64-bit bitmap row (8 bytes) per cycle from the map RAM until a row
// with a free bit is found (1..64), then goes through ST_PICK and ST_MUL to ST_RESP;
// when nothing is free all 64 rows are read, with no pick or multiply.
// Reset clears the per-row valid bits, so the map reads as all zero at once.
// rsp_valid is a one-cycle strobe; the receiver cannot stall it.
module bitmap_first_free_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [bffa_pkg::BIDX_W-1:0]      req_byte_index,
   input  logic [bffa_pkg::BYTE_W-1:0]      req_byte_value,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [bffa_pkg::SLOT_W-1:0]      rsp_slot_number,
   output logic [bffa_pkg::ADDR_W-1:0]      rsp_block_position,
   output logic [bffa_pkg::BIDX_W-1:0]      rsp_changed_byte_index,
   output logic [bffa_pkg::BYTE_W-1:0]      rsp_changed_byte_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bffa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bffa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bffa_pkg::*;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [LANE_W-1:0]     lane_ff, lane_in;
   logic [BYTE_W-1:0]     ld_val_ff, ld_val_in;
   logic [ROW_DATA_W-1:0] hit_ff, hit_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [BYTE_W-1:0]     cval_ff, cval_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [BSIZE_W-1:0]    block_size_ff;
   logic [ADDR_W-1:0]     region_base_ff;

   logic                  rd_en;
   logic [ROW_W-1:0]      rd_row;
   logic [ROW_DATA_W-1:0] rd_data;
   map_wr_type            wr;

   logic [ROW_DATA_W-1:0] merged;
   logic [LANE_W-1:0]     hit_lane;
   logic [BIT_W-1:0]      hit_bit;
   logic [BYTE_W-1:0]     hit_byte;

   bffa_map_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RST;
         region_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BLOCK_SIZE:  block_size_ff  <= csr_data[BSIZE_W-1:0];
            REG_REGION_BASE: region_base_ff <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // load merge: replace one byte of the row just read
   always_comb begin
      for (int l = 0; l < ROW_BYTES; l++) begin
         merged[l*BYTE_W +: BYTE_W] = (LANE_W'(l) == lane_ff) ?
                                      ld_val_ff : rd_data[l*BYTE_W +: BYTE_W];
      end
   end

   // first nonzero byte of the hit row, then its lowest set bit
   always_comb begin
      hit_lane = '0;
      for (int l = ROW_BYTES - 1; l >= 0; l--) begin
         if (|hit_ff[l*BYTE_W +: BYTE_W]) hit_lane = LANE_W'(l);
      end
      hit_byte = hit_ff[hit_lane*BYTE_W +: BYTE_W];
      hit_bit  = lowest_set8(hit_byte);
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      lane_in   = lane_ff;
      ld_val_in = ld_val_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      cval_in   = cval_ff;
      prod_in   = prod_ff;
      rd_en     = 1'b0;
      rd_row    = row_ff;
      wr.en     = 1'b0;
      wr.row    = row_ff;
      wr.data   = merged;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               found_in = 1'b0;
               rd_en    = 1'b1;
               if (req_command == CMD_LOAD) begin
                  row_in    = req_byte_index[BIDX_W-1 -: ROW_W];
                  lane_in   = req_byte_index[LANE_W-1:0];
                  ld_val_in = req_byte_value;
                  rd_row    = req_byte_index[BIDX_W-1 -: ROW_W];
                  state_in  = ST_LOAD_WR;
               end else begin
                  row_in   = '0;
                  rd_row   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD_WR: begin
            wr.en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // rd_data holds row row_ff
            if (|rd_data) begin
               hit_in   = rd_data;
               state_in = ST_PICK;
            end else if (row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_row   = row_ff + 1'b1;
               row_in   = row_ff + 1'b1;
            end
         end
         ST_PICK: begin
            wr.en    = 1'b1;
            wr.data  = hit_ff & ~(ROW_DATA_W'(1) << {hit_lane, hit_bit});
            found_in = 1'b1;
            slot_in  = {row_ff, hit_lane, hit_bit};
            lane_in  = hit_lane;
            cval_in  = hit_byte & ~(BYTE_W'(1) << hit_bit);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(slot_ff) * PROD_W'(block_size_ff);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      lane_ff   <= lane_in;
      ld_val_ff <= ld_val_in;
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      cval_ff   <= cval_in;
      prod_ff   <= prod_in;
   end

   assign busy = (state_ff != ST_IDLE);

   assign rsp_found              = found_ff;
   assign rsp_slot_number        = found_ff ? slot_ff : '0;
   assign rsp_block_position     = found_ff ?
                                   (ADDR_W'(prod_ff) + region_base_ff) : '0;
   assign rsp_changed_byte_index = found_ff ? {row_ff, lane_ff} : '0;
   assign rsp_changed_byte_value = found_ff ? cval_ff : '0;

endmodule
